// ===== src/pcwrl_pkg.sv =====
// Shared types and constants of the per-client window rate limiter.
package pcwrl_pkg;

    localparam logic [63:0] HASH_SEED = 64'd5381;

    localparam int SLOT_INDEX_W = 10;
    localparam int CFG_INDEX_W  = 8;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_REQUEST_LIMIT  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SECONDS = 8'd1;

    localparam logic [15:0] LIMIT_RESET  = 16'd60;
    localparam logic [15:0] WINDOW_RESET = 16'd10;

    typedef enum logic [2:0] {
        VERDICT_NEW     = 3'd0,
        VERDICT_RESTART = 3'd1,
        VERDICT_COUNTED = 3'd2,
        VERDICT_OVER    = 3'd3,
        VERDICT_FULL    = 3'd4
    } t_verdict;

    typedef struct packed {
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [31:0] now_seconds;
    } t_request;

    typedef struct packed {
        logic        used;
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [31:0] window_start;
        logic [15:0] count;
    } t_slot_entry;

endpackage

// ===== src/pcwrl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pcwrl_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [W-1:0]  i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [W-1:0]  o_rd_data
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/pcwrl_fifo.sv =====
// Short first-word-fall-through queue between the front and back parts.
module pcwrl_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_wr_ptr;
    logic [AW-1:0] n_rd_ptr;

    assign n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue read while empty");

endmodule

// ===== src/pcwrl_front.sv =====
// Front part: takes a request, hashes the address and reduces it to a start slot.
module pcwrl_front import pcwrl_pkg::*; #(
    parameter int SLOTS = 1024,
    localparam int SW   = $clog2(SLOTS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  t_request      i_req,
    input  logic          i_block,
    output logic          o_busy,
    output logic          o_push,
    output t_request      o_req,
    output logic [SW-1:0] o_start_slot,
    input  logic          i_full
);

    localparam int SWP = SW + 1;
    localparam logic [SW:0] SLOTS_EXT = SWP'(SLOTS);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_HASH = 4'b0010,
        F_MOD  = 4'b0100,
        F_PUSH = 4'b1000
    } t_front_state;

    t_front_state  r_state;
    logic [3:0]    r_step;
    t_request      r_req;
    logic [63:0]   r_hash;
    logic [SW-1:0] r_rem;

    logic [127:0]  w_key;
    logic [7:0]    w_byte;
    logic [63:0]   n_hash;
    logic [SW-1:0] n_rem;
    logic          w_accept;

    // Bytes are taken most significant first from the 128-bit address.
    assign w_key    = {r_req.addr_high, r_req.addr_low};
    assign w_byte   = w_key[{~r_step, 3'b000} +: 8];
    assign n_hash   = ((r_hash << 5) + r_hash) ^ {56'd0, w_byte};
    assign w_accept = i_start && !o_busy;

    // Four bits of the hash per cycle into the running remainder.
    always_comb begin
        logic [SW:0]   t;
        logic [SW-1:0] rem;
        rem = r_rem;
        for (int k = 0; k < 4; k++) begin
            t = {rem, r_hash[63-k]};
            if (t >= SLOTS_EXT) begin
                t = t - SLOTS_EXT;
            end
            rem = t[SW-1:0];
        end
        n_rem = rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_step  <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (w_accept) begin
                        r_state <= F_HASH;
                        r_step  <= '0;
                    end
                end
                F_HASH: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 4'd15) begin
                        r_state <= F_MOD;
                    end
                end
                F_MOD: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 4'd15) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && w_accept) begin
            r_req  <= i_req;
            r_hash <= HASH_SEED;
        end else if (r_state == F_HASH) begin
            r_hash <= n_hash;
            r_rem  <= '0;
        end else if (r_state == F_MOD) begin
            r_hash <= r_hash << 4;
            r_rem  <= n_rem;
        end
    end

    assign o_busy       = (r_state != F_IDLE) || i_block;
    assign o_push       = (r_state == F_PUSH) && !i_full;
    assign o_req        = r_req;
    assign o_start_slot = r_rem;

    a_accept_starts_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == F_HASH && r_step == 4'd0))
        else $error("accepted request did not enter hashing");

endmodule

// ===== src/pcwrl_back.sv =====
// Back part: probes the slot table from the start slot and issues the verdict.
module pcwrl_back import pcwrl_pkg::*; #(
    parameter int SLOTS = 1024,
    localparam int SW   = $clog2(SLOTS)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_empty,
    output logic                    o_pop,
    input  t_request                i_req,
    input  logic [SW-1:0]           i_start_slot,
    input  logic [15:0]             i_request_limit,
    input  logic [15:0]             i_window_seconds,
    output logic                    o_clearing,
    output logic                    o_valid,
    output logic                    o_allowed,
    output logic [2:0]              o_verdict,
    output logic [SLOT_INDEX_W-1:0] o_slot_index
);

    localparam int EW = $bits(t_slot_entry);
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

    typedef enum logic [4:0] {
        B_CLEAR  = 5'b00001,
        B_IDLE   = 5'b00010,
        B_READ   = 5'b00100,
        B_EVAL   = 5'b01000,
        B_DECIDE = 5'b10000
    } t_back_state;

    t_back_state   r_state;
    logic [SW-1:0] r_clr_addr;
    t_request      r_req;
    logic [SW-1:0] r_slot;
    logic [SW-1:0] r_probe;
    logic          r_used;
    logic          r_match;
    logic          r_expired;
    logic          r_over;
    logic [31:0]   r_ws;
    logic [15:0]   r_count;

    logic                    r_out_valid;
    logic                    r_out_allowed;
    t_verdict                r_out_verdict;
    logic [SLOT_INDEX_W-1:0] r_out_slot;

    logic          w_wr_en;
    logic [SW-1:0] w_wr_addr;
    t_slot_entry   w_wr_data;
    logic [EW-1:0] w_rd_raw;
    t_slot_entry   w_rd;
    logic [31:0]   w_elapsed;
    logic          w_done;
    logic          n_allowed;
    t_verdict      n_verdict;
    logic [SW-1:0] n_slot;

    pcwrl_ram #(
        .W     (EW),
        .DEPTH (SLOTS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (r_state == B_READ),
        .i_rd_addr (r_slot),
        .o_rd_data (w_rd_raw)
    );

    assign w_rd      = t_slot_entry'(w_rd_raw);
    assign w_elapsed = r_req.now_seconds - w_rd.window_start;
    assign n_slot    = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;

    // Outcome of the slot that has just been evaluated.
    always_comb begin
        w_done    = 1'b1;
        n_allowed = 1'b1;
        n_verdict = VERDICT_NEW;
        if (!r_used) begin
            n_verdict = VERDICT_NEW;
        end else if (r_match && r_expired) begin
            n_verdict = VERDICT_RESTART;
        end else if (r_match && r_over) begin
            n_allowed = 1'b0;
            n_verdict = VERDICT_OVER;
        end else if (r_match) begin
            n_verdict = VERDICT_COUNTED;
        end else if (r_probe == LAST_SLOT) begin
            n_allowed = 1'b0;
            n_verdict = VERDICT_FULL;
        end else begin
            w_done = 1'b0;
        end
    end

    // Table writes: the clearing sweep, a claim, a restart or a count.
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_slot;
        w_wr_data = '0;
        if (r_state == B_CLEAR) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr_addr;
        end else if (r_state == B_DECIDE) begin
            w_wr_en = (n_verdict == VERDICT_NEW) || (n_verdict == VERDICT_RESTART)
                      || (n_verdict == VERDICT_COUNTED);
            w_wr_en                = w_wr_en && w_done;
            w_wr_data.used         = 1'b1;
            w_wr_data.key_high     = r_req.addr_high;
            w_wr_data.key_low      = r_req.addr_low;
            w_wr_data.window_start = r_req.now_seconds;
            w_wr_data.count        = 16'd1;
            if (n_verdict == VERDICT_COUNTED) begin
                w_wr_data.window_start = r_ws;
                w_wr_data.count        = r_count + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            case (r_state)
                B_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == LAST_SLOT) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (!i_empty) begin
                        r_state <= B_READ;
                    end
                end
                B_READ: begin
                    r_state <= B_EVAL;
                end
                B_EVAL: begin
                    r_state <= B_DECIDE;
                end
                B_DECIDE: begin
                    if (w_done) begin
                        r_out_valid <= 1'b1;
                        r_state     <= B_IDLE;
                    end else begin
                        r_state <= B_READ;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_req   <= i_req;
                r_slot  <= i_start_slot;
                r_probe <= '0;
            end
            B_EVAL: begin
                r_used    <= w_rd.used;
                r_match   <= (w_rd.key_high == r_req.addr_high)
                             && (w_rd.key_low == r_req.addr_low);
                r_expired <= (r_req.now_seconds >= w_rd.window_start)
                             && (w_elapsed >= {16'd0, i_window_seconds});
                r_over    <= (w_rd.count >= i_request_limit);
                r_ws      <= w_rd.window_start;
                r_count   <= w_rd.count;
            end
            B_DECIDE: begin
                if (w_done) begin
                    r_out_allowed <= n_allowed;
                    r_out_verdict <= n_verdict;
                    r_out_slot    <= (n_verdict == VERDICT_FULL) ? '0
                                     : SLOT_INDEX_W'(r_slot);
                end else begin
                    r_slot  <= n_slot;
                    r_probe <= r_probe + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_pop        = (r_state == B_IDLE) && !i_empty;
    assign o_clearing   = (r_state == B_CLEAR);
    assign o_valid      = r_out_valid;
    assign o_allowed    = r_out_allowed;
    assign o_verdict    = r_out_verdict;
    assign o_slot_index = r_out_slot;

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |=> !r_out_valid)
        else $error("result strobe held for more than one cycle");

    a_full_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_verdict == VERDICT_FULL) |-> (!r_out_allowed && r_out_slot == '0))
        else $error("full-table verdict admitted or named a slot");

    a_clear_writes_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CLEAR) |-> (w_wr_en && !w_wr_data.used && !o_pop))
        else $error("clearing sweep did not free the slot");

endmodule

// ===== src/per_client_window_rate_limiter.sv =====
// Top level of the per-client fixed-window rate limiter.
//
// Requests are offered on start with the 128-bit client address and the
// current time in seconds; a beat is taken at a rising edge where start is
// high and busy is low. Each request yields exactly one result beat on
// o_valid, o_allowed, o_verdict and o_slot_index, shown for a single cycle.
// The receiver cannot stall, so results are never held back.
// The front part hashes the 16 address bytes and then reduces the hash to a
// start slot; it takes no new request until it has pushed the last one into
// the queue, and waits longer while the queue is full. The back part takes a
// beat from the queue and then steps through read, compare and decide on each
// slot probed against the slot table RAM, with the result in the cycle after
// the final decide step. A two-beat queue separates the two, so one request
// can be hashed while an earlier one is probed.
// After reset the table is swept clear, one slot per cycle, and busy stays
// high meanwhile. Configuration writes are taken at any time on their own
// channel and return to 60 requests per 10 seconds at reset.
module per_client_window_rate_limiter import pcwrl_pkg::*; #(
    parameter int SLOTS       = 1024,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [63:0]             i_addr_high,
    input  logic [63:0]             i_addr_low,
    input  logic [31:0]             i_now_seconds,
    output logic                    o_valid,
    output logic                    o_allowed,
    output logic [2:0]              o_verdict,
    output logic [SLOT_INDEX_W-1:0] o_slot_index,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int SW = $clog2(SLOTS);
    localparam int QW = $bits(t_request) + SW;

    logic [15:0]   r_request_limit;
    logic [15:0]   r_window_seconds;

    t_request      w_in_req;
    t_request      w_front_req;
    logic [SW-1:0] w_front_slot;
    logic          w_push;
    logic          w_full;
    logic          w_pop;
    logic          w_empty;
    logic [QW-1:0] w_queue_out;
    logic          w_clearing;

    // Configuration is always accepted; indexes outside the list are ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_request_limit  <= LIMIT_RESET;
            r_window_seconds <= WINDOW_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_REQUEST_LIMIT: begin
                    r_request_limit <= i_cfg_data;
                end
                CFG_WINDOW_SECONDS: begin
                    r_window_seconds <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign w_in_req.addr_high   = i_addr_high;
    assign w_in_req.addr_low    = i_addr_low;
    assign w_in_req.now_seconds = i_now_seconds;

    // The front part stays closed while the table sweep is running.
    pcwrl_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_req        (w_in_req),
        .i_block      (w_clearing),
        .o_busy       (busy),
        .o_push       (w_push),
        .o_req        (w_front_req),
        .o_start_slot (w_front_slot),
        .i_full       (w_full)
    );

    pcwrl_fifo #(
        .W     (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_front_req, w_front_slot}),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_queue_out),
        .o_empty (w_empty)
    );

    // The back part owns the slot table and drives the result beat directly.
    pcwrl_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (w_empty),
        .o_pop            (w_pop),
        .i_req            (t_request'(w_queue_out[QW-1:SW])),
        .i_start_slot     (w_queue_out[SW-1:0]),
        .i_request_limit  (r_request_limit),
        .i_window_seconds (r_window_seconds),
        .o_clearing       (w_clearing),
        .o_valid          (o_valid),
        .o_allowed        (o_allowed),
        .o_verdict        (o_verdict),
        .o_slot_index     (o_slot_index)
    );

endmodule

// ===== dv/per_client_window_rate_limiter_tb.sv =====
// Self-checking testbench of the per-client window rate limiter.
//
// A predictor written here keeps its own copy of the slot table and of the
// two limit registers, and works out the verdict for every request beat at
// the edge where the block takes it. The expected verdicts wait in a queue
// in order, and each result beat is compared, field by field, with the
// oldest one.
//
// The run has two parts:
//   - a short directed table covering the field extremes, window expiry,
//     time running backwards, a zero window and a zero limit, with
//     register writes between the rows;
//   - random bursts from a pool of returning clients under several limit
//     and window settings, with some fresh clients and jumps in time mixed
//     in.
//
// Registers are written only once every expected result has arrived. The
// sender may pause before each beat; some whole bursts are sent at no gap.
module per_client_window_rate_limiter_tb;
    import pcwrl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = 1024;
    localparam int POOL_SIZE    = 40;
    localparam int PHASE_ITEMS  = 120;
    localparam int SETTLE       = 400;
    localparam int MAX_REPORTS  = 10;
    localparam int CYCLE_LIMIT  = 2_000_000;

    // One verdict as the block reports it.
    typedef struct {
        logic                    allowed;
        t_verdict                verdict;
        logic [SLOT_INDEX_W-1:0] slot;
    } t_outcome;

    typedef enum logic {
        ROW_REQUEST,
        ROW_REGISTER
    } t_row_kind;

    // One row of the directed table. Where known is set, the admit bit and
    // verdict of the row are typed in; the slot always comes from the
    // predictor, since it hangs on the hash.
    typedef struct {
        t_row_kind              kind;
        logic [63:0]            addr_high;
        logic [63:0]            addr_low;
        logic [31:0]            now_seconds;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_data;
        bit                     known;
        logic                   known_allowed;
        t_verdict               known_verdict;
    } t_plan_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [63:0]             i_addr_high;
    logic [63:0]             i_addr_low;
    logic [31:0]             i_now_seconds;
    logic                    o_valid;
    logic                    o_allowed;
    logic [2:0]              o_verdict;
    logic [SLOT_INDEX_W-1:0] o_slot_index;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_INDEX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    per_client_window_rate_limiter #(
        .SLOTS (SLOTS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_addr_high   (i_addr_high),
        .i_addr_low    (i_addr_low),
        .i_now_seconds (i_now_seconds),
        .o_valid       (o_valid),
        .o_allowed     (o_allowed),
        .o_verdict     (o_verdict),
        .o_slot_index  (o_slot_index),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Predictor state: the slot table and the two registers as the block
    // should hold them.
    bit          slot_used  [SLOTS];
    logic [63:0] slot_key_hi[SLOTS];
    logic [63:0] slot_key_lo[SLOTS];
    logic [31:0] slot_start [SLOTS];
    logic [15:0] slot_count [SLOTS];
    logic [15:0] cur_limit;
    logic [15:0] cur_window;

    t_outcome    pending_verdicts[$];
    t_plan_row   plan[$];
    logic [63:0] pool_hi[POOL_SIZE];
    logic [63:0] pool_lo[POOL_SIZE];

    int          mismatches;
    int          requests_sent;
    int          verdicts_checked;
    int          verdict_seen[5];
    int          cycles = 0;

    // Clock and the one reset at the start.
    initial begin
        i_clk = 1'b0;
    end

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d verdicts still outstanding",
                     cycles, pending_verdicts.size());
            $display("[per_client_window_rate_limiter] ERROR");
            $finish;
        end
    end

    // xor form of the djb2 recurrence over the 16 address bytes, most
    // significant first, wrapping at 64 bits.
    function automatic logic [63:0] addr_digest(input logic [63:0] hi, input logic [63:0] lo);
        logic [127:0] key;
        logic [63:0]  h;
        key = {hi, lo};
        h   = HASH_SEED;
        for (int b = 15; b >= 0; b--) begin
            h = (h * 64'd33) ^ {56'd0, key[b*8 +: 8]};
        end
        return h;
    endfunction

    function automatic int home_slot(input logic [63:0] hi, input logic [63:0] lo);
        return int'(addr_digest(hi, lo) % 64'(SLOTS));
    endfunction

    // Works out the verdict for one request and updates the table copy the
    // way the block should: probe from the home slot, claim the first free
    // slot, or act on the slot whose key matches.
    function automatic t_outcome admit_request(input logic [63:0] hi, input logic [63:0] lo,
                                               input logic [31:0] now);
        t_outcome res;
        int       home;
        int       s;
        bit       settled;
        home        = home_slot(hi, lo);
        res.allowed = 1'b0;
        res.verdict = VERDICT_FULL;
        res.slot    = '0;
        settled     = 1'b0;
        for (int i = 0; i < SLOTS && !settled; i++) begin
            s = (home + i) % SLOTS;
            if (!slot_used[s]) begin
                slot_used[s]   = 1'b1;
                slot_key_hi[s] = hi;
                slot_key_lo[s] = lo;
                slot_start[s]  = now;
                slot_count[s]  = 16'd1;
                res.allowed = 1'b1;
                res.verdict = VERDICT_NEW;
                settled     = 1'b1;
            end else if (slot_key_hi[s] == hi && slot_key_lo[s] == lo) begin
                // A time earlier than the stored start never expires the window.
                if (now >= slot_start[s] && (now - slot_start[s]) >= {16'd0, cur_window}) begin
                    slot_start[s] = now;
                    slot_count[s] = 16'd1;
                    res.allowed   = 1'b1;
                    res.verdict   = VERDICT_RESTART;
                end else if (slot_count[s] >= cur_limit) begin
                    res.allowed = 1'b0;
                    res.verdict = VERDICT_OVER;
                end else begin
                    slot_count[s] = slot_count[s] + 16'd1;
                    res.allowed   = 1'b1;
                    res.verdict   = VERDICT_COUNTED;
                end
                settled = 1'b1;
            end
            if (settled) begin
                res.slot = SLOT_INDEX_W'(s);
            end
        end
        return res;
    endfunction

    function automatic void report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch at cycle %0d: %s", cycles, what);
        end
    endfunction

    // Result checker. Outputs are read in the active region right after the
    // rising edge, so they still hold the values of the cycle that ends there.
    always @(posedge i_clk) begin : result_check
        t_outcome want;
        if (i_rst_n && o_valid) begin
            if (o_verdict < 3'd5) begin
                verdict_seen[o_verdict]++;
            end
            if (pending_verdicts.size() == 0) begin
                report_mismatch($sformatf(
                    "result beat with nothing expected: allowed %0b verdict %0d slot %0d",
                    o_allowed, o_verdict, o_slot_index));
            end else begin
                want = pending_verdicts.pop_front();
                verdicts_checked++;
                if (o_allowed !== want.allowed || o_verdict !== want.verdict ||
                    o_slot_index !== want.slot) begin
                    report_mismatch($sformatf(
                        "expected allowed %0b verdict %s slot %0d, got allowed %0b verdict %0d slot %0d",
                        want.allowed, want.verdict.name(), want.slot,
                        o_allowed, o_verdict, o_slot_index));
                end
            end
        end
    end

    // Offers one request beat after a gap and holds it until the block takes
    // it. The verdict is predicted at the edge of acceptance, so it sees any
    // register write that went before it. Start is only lowered during the
    // gap, so a beat that follows straight on keeps it high.
    task automatic offer_request(input logic [63:0] hi, input logic [63:0] lo,
                                 input logic [31:0] now, input int gap, input bit known,
                                 input logic known_allowed, input t_verdict known_verdict);
        t_outcome want;
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start         <= 1'b1;
        i_addr_high   <= hi;
        i_addr_low    <= lo;
        i_now_seconds <= now;
        do @(posedge i_clk); while (busy);
        want = admit_request(hi, lo, now);
        if (known) begin
            want.allowed = known_allowed;
            want.verdict = known_verdict;
        end
        pending_verdicts.push_back(want);
        requests_sent++;
    endtask

    // Registers change only while the block is idle, so the last request
    // beat is withdrawn and every outstanding verdict is awaited first.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == CFG_REQUEST_LIMIT) begin
            cur_limit = data;
        end else if (index == CFG_WINDOW_SECONDS) begin
            cur_window = data;
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void plan_request(input logic [63:0] hi, input logic [63:0] lo,
                                         input logic [31:0] now, input bit known,
                                         input logic known_allowed, input t_verdict known_verdict);
        t_plan_row row;
        row.kind          = ROW_REQUEST;
        row.addr_high     = hi;
        row.addr_low      = lo;
        row.now_seconds   = now;
        row.reg_index     = '0;
        row.reg_data      = '0;
        row.known         = known;
        row.known_allowed = known_allowed;
        row.known_verdict = known_verdict;
        plan.push_back(row);
    endfunction

    function automatic void plan_register(input logic [CFG_INDEX_W-1:0] index,
                                          input logic [CFG_DATA_W-1:0] data);
        t_plan_row row;
        row.kind          = ROW_REGISTER;
        row.addr_high     = '0;
        row.addr_low      = '0;
        row.now_seconds   = '0;
        row.reg_index     = index;
        row.reg_data      = data;
        row.known         = 1'b0;
        row.known_allowed = 1'b0;
        row.known_verdict = VERDICT_NEW;
        plan.push_back(row);
    endfunction

    initial begin : stimulus
        logic [15:0] phase_limit [5];
        logic [15:0] phase_window[5];
        logic [63:0] hi;
        logic [63:0] lo;
        logic [31:0] wall;
        logic [31:0] now;
        int          sent;
        int          pick;
        int          burst;
        int          roll;
        bit          steady;

        // Every input is known from time zero.
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_addr_high   = '0;
        i_addr_low    = '0;
        i_now_seconds = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        mismatches    = 0;
        requests_sent = 0;
        verdicts_checked = 0;
        cur_limit     = LIMIT_RESET;
        cur_window    = WINDOW_RESET;
        foreach (slot_used[k]) slot_used[k] = 1'b0;
        foreach (verdict_seen[k]) verdict_seen[k] = 0;

        // The client pool: half as IPv4 mapped into IPv6, half fully random.
        for (int k = 0; k < POOL_SIZE; k++) begin
            if (k % 2 == 0) begin
                pool_hi[k] = 64'd0;
                pool_lo[k] = {32'h0000_FFFF, 32'($urandom)};
            end else begin
                pool_hi[k] = {32'($urandom), 32'($urandom)};
                pool_lo[k] = {32'($urandom), 32'($urandom)};
            end
        end

        // Directed table. The reset limits of 60 per 10 seconds hold until
        // the first register row.
        plan_request(64'd0, 64'd0, 32'd0, 1'b1, 1'b1, VERDICT_NEW);
        plan_request(64'd0, 64'd0, 32'd5, 1'b1, 1'b1, VERDICT_COUNTED);
        // Exactly one window later the count starts again.
        plan_request(64'd0, 64'd0, 32'd10, 1'b1, 1'b1, VERDICT_RESTART);
        plan_request('1, '1, 32'hFFFF_FFFF, 1'b1, 1'b1, VERDICT_NEW);
        // Time far below the window start does not expire the window.
        plan_request('1, '1, 32'd0, 1'b1, 1'b1, VERDICT_COUNTED);
        plan_register(CFG_REQUEST_LIMIT, 16'd2);
        plan_request('1, '1, 32'd1, 1'b1, 1'b0, VERDICT_OVER);
        plan_register(CFG_WINDOW_SECONDS, 16'hFFFF);
        plan_request(64'd0, 64'd0, 32'd65544, 1'b1, 1'b1, VERDICT_COUNTED);
        plan_request(64'd0, 64'd0, 32'd65545, 1'b1, 1'b1, VERDICT_RESTART);
        // A zero limit refuses matches within the window but still admits new clients.
        plan_register(CFG_REQUEST_LIMIT, 16'd0);
        plan_request(64'd0, 64'd0, 32'd65545, 1'b1, 1'b0, VERDICT_OVER);
        plan_request(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 32'd100,
                     1'b1, 1'b1, VERDICT_NEW);
        // A zero window expires on every match that is not earlier than the start.
        plan_register(CFG_WINDOW_SECONDS, 16'd0);
        plan_request(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 32'd100,
                     1'b1, 1'b1, VERDICT_RESTART);
        plan_request(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 32'd99,
                     1'b1, 1'b0, VERDICT_OVER);
        plan_register(CFG_REQUEST_LIMIT, 16'hFFFF);
        plan_request(64'd0, 64'd1, 32'd7, 1'b1, 1'b1, VERDICT_NEW);
        plan_request(64'd0, 64'd1, 32'd7, 1'b1, 1'b1, VERDICT_RESTART);
        plan_request(64'd0, 64'h0000_FFFF_C0A8_0001, 32'h8000_0000, 1'b0, 1'b0, VERDICT_NEW);
        plan_request(64'd0, 64'h0000_FFFF_C0A8_0001, 32'h7FFF_FFFF, 1'b0, 1'b0, VERDICT_NEW);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_REGISTER) begin
                write_register(plan[r].reg_index, plan[r].reg_data);
            end else begin
                offer_request(plan[r].addr_high, plan[r].addr_low, plan[r].now_seconds,
                              $urandom_range(0, 9), plan[r].known,
                              plan[r].known_allowed, plan[r].known_verdict);
            end
        end

        // Random bursts under several settings, the extremes among them.
        phase_limit  = '{16'd3, 16'd1, 16'hFFFF, 16'd0, 16'd7};
        phase_window = '{16'd5, 16'd1, 16'hFFFF, 16'd0, 16'd30};
        wall = $urandom;
        for (int p = 0; p < 5; p++) begin
            write_register(CFG_REQUEST_LIMIT, phase_limit[p]);
            write_register(CFG_WINDOW_SECONDS, phase_window[p]);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                steady = ($urandom_range(0, 3) == 0);
                roll   = $urandom_range(0, 99);
                if (roll < 8) begin
                    wall = $urandom;
                end else if (roll < 12) begin
                    wall = 32'hFFFF_FFFF - 32'($urandom_range(0, 20));
                end else if (roll < 40) begin
                    wall = wall + 32'($urandom_range(0, 2 * int'(cur_window) + 2));
                end else begin
                    wall = wall + 32'($urandom_range(0, 2));
                end
                if ($urandom_range(0, 9) == 0) begin
                    // A lone beat from a client never seen before.
                    hi = {32'($urandom), 32'($urandom)};
                    lo = {32'($urandom), 32'($urandom)};
                    offer_request(hi, lo, wall, steady ? 0 : $urandom_range(0, 9),
                                  1'b0, 1'b0, VERDICT_NEW);
                    sent++;
                end else begin
                    pick  = $urandom_range(0, POOL_SIZE - 1);
                    burst = $urandom_range(1, 10);
                    for (int b = 0; b < burst; b++) begin
                        // Now and then time runs back a few seconds.
                        if ($urandom_range(0, 9) == 0) begin
                            now = wall - 32'($urandom_range(1, 3));
                        end else begin
                            wall = wall + 32'($urandom_range(0, 2));
                            now  = wall;
                        end
                        offer_request(pool_hi[pick], pool_lo[pick], now,
                                      steady ? 0 : $urandom_range(0, 9),
                                      1'b0, 1'b0, VERDICT_NEW);
                        sent++;
                    end
                end
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        // Any stray result beat after the last expected one is caught here.
        repeat (SETTLE) @(posedge i_clk);

        $display("%0d requests sent, %0d verdicts checked in %0d cycles, %0d mismatches",
                 requests_sent, verdicts_checked, cycles, mismatches);
        $display("verdicts seen: new %0d, restarted %0d, counted %0d, over limit %0d, full %0d",
                 verdict_seen[0], verdict_seen[1], verdict_seen[2], verdict_seen[3],
                 verdict_seen[4]);
        if (mismatches == 0 && pending_verdicts.size() == 0) begin
            $display("[per_client_window_rate_limiter] OK");
        end else begin
            $display("[per_client_window_rate_limiter] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/pcwrl_pkg.sv
src/pcwrl_ram.sv
src/pcwrl_fifo.sv
src/pcwrl_front.sv
src/pcwrl_back.sv
src/per_client_window_rate_limiter.sv
dv/per_client_window_rate_limiter_tb.sv
